// ----- hdl/depth_frame_range_gate_average_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion forms for the depth frame range gate average core.
// ----------------------------------------------------------------------------
`ifndef DEPTH_FRAME_RANGE_GATE_AVERAGE_CORE_MACROS_SVH
`define DEPTH_FRAME_RANGE_GATE_AVERAGE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define DFRGA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define DFRGA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/dfrga_pkg.sv -----
// ----------------------------------------------------------------------------
// dfrga_pkg
// Types, sizes and the reciprocal table of the depth frame averaging core.
// ----------------------------------------------------------------------------
`default_nettype none

package dfrga_pkg;

   localparam int PIXELS    = 307200;
   localparam int MAX_SCANS = 16;

   localparam int DEPTH_W   = 15;
   localparam int AVG_W     = 19;
   localparam int KEPT_W    = 5;
   localparam int INDEX_W   = 19;
   localparam int SCANS_W   = 5;
   localparam int SUM_W     = 19;
   localparam int PIX_W     = (PIXELS > 1) ? $clog2(PIXELS) : 1;
   localparam int SCAN_W    = (MAX_SCANS > 1) ? $clog2(MAX_SCANS) : 1;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 15;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int DIVD_W      = SUM_W + 4;
   localparam int RECIP_W     = 28;
   localparam int RECIP_SHIFT = 27;
   localparam int PROD_W      = DIVD_W + RECIP_W;

   localparam logic [DEPTH_W-1:0] MIN_DIST_RESET = 15'd450;
   localparam logic [DEPTH_W-1:0] MAX_DIST_RESET = 15'd800;
   localparam logic [SCANS_W-1:0] SCANS_RESET    = 5'd5;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_DISTANCE = 2'd0,
      CSR_MAX_DISTANCE = 2'd1,
      CSR_SCAN_COUNT   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [PIX_W-1:0]   pos;
      logic [DEPTH_W-1:0] sample;
      logic               keep;
      logic               first;
      logic               last;
      logic               frame_last;
   } work_item_type;

   typedef struct packed {
      logic [SUM_W-1:0]  sum;
      logic [KEPT_W-1:0] cnt;
   } entry_type;

   // ceil(2^27 / c): exact quotient for 23-bit dividends and c up to 16.
   function automatic logic [RECIP_W-1:0] recip(input logic [KEPT_W-1:0] c);
      logic [RECIP_W-1:0] r;
      case (c)
         5'd1:    r = 28'd134217728;
         5'd2:    r = 28'd67108864;
         5'd3:    r = 28'd44739243;
         5'd4:    r = 28'd33554432;
         5'd5:    r = 28'd26843546;
         5'd6:    r = 28'd22369622;
         5'd7:    r = 28'd19173962;
         5'd8:    r = 28'd16777216;
         5'd9:    r = 28'd14913081;
         5'd10:   r = 28'd13421773;
         5'd11:   r = 28'd12201612;
         5'd12:   r = 28'd11184811;
         5'd13:   r = 28'd10324441;
         5'd14:   r = 28'd9586981;
         5'd15:   r = 28'd8947849;
         5'd16:   r = 28'd8388608;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/dfrga_channels.sv -----
// ----------------------------------------------------------------------------
// dfrga channels
// Valid/ready channel interfaces for pixels, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface dfrga_req_if;
   logic                            valid;
   logic                            ready;
   logic [dfrga_pkg::DEPTH_W-1:0]   depth_sample;
   logic                            in_region;
   modport source (output valid, depth_sample, in_region, input ready);
   modport sink   (input valid, depth_sample, in_region, output ready);
endinterface

interface dfrga_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [dfrga_pkg::AVG_W-1:0]     averaged_depth;
   logic [dfrga_pkg::KEPT_W-1:0]    kept_samples;
   logic [dfrga_pkg::INDEX_W-1:0]   pixel_index;
   logic                            frame_last;
   modport source (output valid, averaged_depth, kept_samples, pixel_index, frame_last,
                   input ready);
   modport sink   (input valid, averaged_depth, kept_samples, pixel_index, frame_last,
                   output ready);
endinterface

interface dfrga_csr_if;
   logic                            valid;
   logic                            ready;
   logic [dfrga_pkg::CSR_IDX_W-1:0] index;
   logic [dfrga_pkg::CSR_DAT_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hdl/depth_frame_range_gate_average_core.sv -----
// ----------------------------------------------------------------------------
// depth_frame_range_gate_average_core
// Range-gated per-pixel averaging of depth frames over several scans.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                           | transfer
//  req_ch   | in  | depth_sample[15], in_region                       | valid & ready
//  rsp_ch   | out | averaged_depth[19], kept_samples[5],              | valid & ready
//           |     | pixel_index[19], frame_last                       |
//  csr_ch   | in  | index[2], data[15]                                | valid & ready
//
//  One pixel per cycle sustained while rsp_ch is not stalled. A result passes
//  the queue, the stage 1 to 3 registers and the result register. The store
//  read/modify/write and the reciprocal multiply are each one stage.
//  A 4-entry queue lets the front take pixels while the back waits on rsp_ch.
//  Reset clears position counters and registers; the store is not cleared
//  since the first scan writes every entry without using its old contents.
// ----------------------------------------------------------------------------
`default_nettype none

`include "depth_frame_range_gate_average_core_macros.svh"

module depth_frame_range_gate_average_core (
   input  logic        clock,
   input  logic        reset,
   dfrga_req_if.sink   req_ch,
   dfrga_rsp_if.source rsp_ch,
   dfrga_csr_if.sink   csr_ch
);
   import dfrga_pkg::*;

   logic          q_push;
   logic          q_pop;
   logic          q_full;
   logic          q_not_empty;
   work_item_type q_item;
   work_item_type q_head;

   dfrga_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .csr_ch (csr_ch),
      .q_full (q_full),
      .q_push (q_push),
      .q_item (q_item)
   );

   dfrga_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_item (q_head)
   );

   dfrga_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_ch      (rsp_ch)
   );

   `DFRGA_ASSERT_NOW(a_frame_last_pos, rsp_ch.valid && rsp_ch.frame_last, rsp_ch.pixel_index == INDEX_W'(PIXELS - 1), "frame_last off the last pixel")
   `DFRGA_ASSERT_NOW(a_kept_bound, rsp_ch.valid, int'(rsp_ch.kept_samples) <= MAX_SCANS, "kept_samples above scan limit")
   `DFRGA_ASSERT_NOW(a_empty_mean, rsp_ch.valid && (rsp_ch.kept_samples == '0), rsp_ch.averaged_depth == '0, "nonzero mean with no kept samples")
   `DFRGA_ASSERT_NEXT(a_queue_push, q_full && !q_pop, !q_not_empty == 1'b0, "queue lost entries while full")

endmodule

`default_nettype wire

// ----- hdl/dfrga_front.sv -----
// ----------------------------------------------------------------------------
// dfrga_front
// Register file, range gate and raster/scan position tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module dfrga_front (
   input  logic                     clock,
   input  logic                     reset,
   dfrga_req_if.sink                req_ch,
   dfrga_csr_if.sink                csr_ch,
   input  logic                     q_full,
   output logic                     q_push,
   output dfrga_pkg::work_item_type q_item
);
   import dfrga_pkg::*;

   logic [DEPTH_W-1:0] min_ff, min_in;
   logic [DEPTH_W-1:0] max_ff, max_in;
   logic [SCANS_W-1:0] scans_ff, scans_in;
   logic [PIX_W-1:0]   pix_ff, pix_in;
   logic [SCAN_W-1:0]  scan_ff, scan_in;

   logic [SCANS_W-1:0] eff_scans;
   logic               last_scan;
   logic               pix_wrap;
   logic               keep;

   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = !q_full;
   assign q_push       = req_ch.valid && !q_full;

   always_comb begin
      if (scans_ff == '0) begin
         eff_scans = SCANS_W'(1);
      end else if (int'(scans_ff) > MAX_SCANS) begin
         eff_scans = SCANS_W'(MAX_SCANS);
      end else begin
         eff_scans = scans_ff;
      end
   end

   assign last_scan = (int'(scan_ff) + 1) >= int'(eff_scans);
   assign pix_wrap  = pix_ff == PIX_W'(PIXELS - 1);
   assign keep      = (req_ch.depth_sample != '0) && req_ch.in_region &&
                      (req_ch.depth_sample >= min_ff) && (req_ch.depth_sample <= max_ff);

   always_comb begin
      q_item.pos        = pix_ff;
      q_item.sample     = req_ch.depth_sample;
      q_item.keep       = keep;
      q_item.first      = scan_ff == '0;
      q_item.last       = last_scan;
      q_item.frame_last = last_scan && pix_wrap;
   end

   always_comb begin
      min_in   = min_ff;
      max_in   = max_ff;
      scans_in = scans_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_MIN_DISTANCE: min_in   = csr_ch.data;
            CSR_MAX_DISTANCE: max_in   = csr_ch.data;
            CSR_SCAN_COUNT:   scans_in = csr_ch.data[SCANS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      pix_in  = pix_ff;
      scan_in = scan_ff;
      if (q_push) begin
         if (pix_wrap) begin
            pix_in  = '0;
            scan_in = last_scan ? '0 : scan_ff + SCAN_W'(1);
         end else begin
            pix_in = pix_ff + PIX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff   <= MIN_DIST_RESET;
         max_ff   <= MAX_DIST_RESET;
         scans_ff <= SCANS_RESET;
         pix_ff   <= '0;
         scan_ff  <= '0;
      end else begin
         min_ff   <= min_in;
         max_ff   <= max_in;
         scans_ff <= scans_in;
         pix_ff   <= pix_in;
         scan_ff  <= scan_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/dfrga_queue.sv -----
// ----------------------------------------------------------------------------
// dfrga_queue
// Small circular queue of classified pixels between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module dfrga_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  dfrga_pkg::work_item_type push_item,
   input  logic                     pop,
   output logic                     full,
   output logic                     not_empty,
   output dfrga_pkg::work_item_type head_item
);
   import dfrga_pkg::*;

   work_item_type     slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in;
   logic [QPTR_W-1:0] rd_ff, rd_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              do_pop;

   assign full      = cnt_ff == QCNT_W'(QUEUE_DEPTH);
   assign not_empty = cnt_ff != '0;
   assign head_item = slots_ff[rd_ff];
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_in  = push ? wr_ff + QPTR_W'(1) : wr_ff;
      rd_in  = do_pop ? rd_ff + QPTR_W'(1) : rd_ff;
      cnt_in = cnt_ff;
      if (push && !do_pop) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (!push && do_pop) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/dfrga_back.sv -----
// ----------------------------------------------------------------------------
// dfrga_back
// Sum/count store update and rounded mean through a reciprocal multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module dfrga_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_not_empty,
   input  dfrga_pkg::work_item_type q_head,
   output logic                     q_pop,
   dfrga_rsp_if.source              rsp_ch
);
   import dfrga_pkg::*;

   entry_type     store [PIXELS];

   logic          en;

   // stage 1: store read data available
   logic          s1_valid_ff;
   work_item_type s1_item_ff;
   entry_type     rd_q_ff;
   logic          fwd_ff;
   entry_type     fwd_data_ff;
   entry_type     base;
   entry_type     upd;

   // stage 2: accumulated entry of a last-scan pixel
   logic               s2_valid_ff;
   entry_type          s2_entry_ff;
   logic [PIX_W-1:0]   s2_pos_ff;
   logic               s2_last_ff;
   logic [DIVD_W-1:0]  dividend;

   // stage 3: product
   logic               s3_valid_ff;
   logic [PROD_W-1:0]  s3_prod_ff;
   logic [KEPT_W-1:0]  s3_cnt_ff;
   logic [PIX_W-1:0]   s3_pos_ff;
   logic               s3_last_ff;

   // result register
   logic               out_valid_ff;
   logic [AVG_W-1:0]   out_avg_ff;
   logic [KEPT_W-1:0]  out_cnt_ff;
   logic [PIX_W-1:0]   out_pos_ff;
   logic               out_last_ff;

   assign en    = !out_valid_ff || rsp_ch.ready;
   assign q_pop = en && q_not_empty;

   assign base = fwd_ff ? fwd_data_ff : rd_q_ff;

   always_comb begin
      upd = base;
      if (s1_item_ff.first) begin
         upd.sum = s1_item_ff.keep ? SUM_W'(s1_item_ff.sample) : '0;
         upd.cnt = s1_item_ff.keep ? KEPT_W'(1) : '0;
      end else if (s1_item_ff.keep) begin
         upd.sum = base.sum + SUM_W'(s1_item_ff.sample);
         upd.cnt = base.cnt + KEPT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rd_q_ff <= store[q_head.pos];
      end
      if (en && s1_valid_ff) begin
         store[s1_item_ff.pos] <= upd;
      end
   end

   // 16*sum + cnt/2, then divided by cnt
   assign dividend = {s2_entry_ff.sum, 4'b0000} + DIVD_W'(s2_entry_ff.cnt >> 1);

   always_ff @(posedge clock) begin
      if (en) begin
         s1_item_ff  <= q_head;
         fwd_ff      <= s1_valid_ff && q_not_empty && (s1_item_ff.pos == q_head.pos);
         fwd_data_ff <= upd;
         s2_entry_ff <= upd;
         s2_pos_ff   <= s1_item_ff.pos;
         s2_last_ff  <= s1_item_ff.frame_last;
         s3_prod_ff  <= PROD_W'(dividend) * PROD_W'(recip(s2_entry_ff.cnt));
         s3_cnt_ff   <= s2_entry_ff.cnt;
         s3_pos_ff   <= s2_pos_ff;
         s3_last_ff  <= s2_last_ff;
         out_avg_ff  <= s3_prod_ff[RECIP_SHIFT +: AVG_W];
         out_cnt_ff  <= s3_cnt_ff;
         out_pos_ff  <= s3_pos_ff;
         out_last_ff <= s3_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff  <= q_not_empty;
         s2_valid_ff  <= s1_valid_ff && s1_item_ff.last;
         s3_valid_ff  <= s2_valid_ff;
         out_valid_ff <= s3_valid_ff;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.averaged_depth = out_avg_ff;
   assign rsp_ch.kept_samples   = out_cnt_ff;
   assign rsp_ch.pixel_index    = INDEX_W'(out_pos_ff);
   assign rsp_ch.frame_last     = out_last_ff;

endmodule

`default_nettype wire

// ----- test/tb_depth_frame_range_gate_average_core.sv -----
// ----------------------------------------------------------------------------
// tb_depth_frame_range_gate_average_core
// Self-checking bench for the range-gated multi-scan depth averaging core.
// Pixels are streamed over valid/ready with random gaps and output stalls.
// A behavioral predictor tracks the per-pixel sums, counts and scan position,
// and each result transfer is compared field by field with the oldest entry
// in the expectation queue. Covers gate edges, min above max, scan count
// zero and saturation, and lowering the scan count partway through a scan
// so that the current scan becomes the last one.
// ----------------------------------------------------------------------------
module tb_depth_frame_range_gate_average_core;
   timeunit 1ns;
   timeprecision 1ps;

   import dfrga_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_INDEX = 2'd3;
   localparam int QUIET_CYCLES = 16;
   localparam int REPORT_LIMIT = 100;
   localparam longint CYCLE_LIMIT = 3_000_000;

   typedef struct packed {
      logic [AVG_W-1:0]   averaged_depth;
      logic [KEPT_W-1:0]  kept_samples;
      logic [INDEX_W-1:0] pixel_index;
      logic               frame_last;
   } pixel_result_type;

   logic clock;
   logic reset;

   dfrga_req_if req_ch();
   dfrga_rsp_if rsp_ch();
   dfrga_csr_if csr_ch();

   depth_frame_range_gate_average_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // predictor state
   logic [DEPTH_W-1:0] gate_min;
   logic [DEPTH_W-1:0] gate_max;
   logic [SCANS_W-1:0] gate_scans;
   int unsigned        pixel_pos;
   int unsigned        scan_pos;
   bit [SUM_W-1:0]     depth_sum [PIXELS];
   bit [KEPT_W-1:0]    hit_count [PIXELS];
   pixel_result_type   pending_averages [$];

   pixel_result_type   oldest_average;
   int                 fail_count;
   longint             cycle_count = 0;
   bit                 pixel_gaps;
   bit                 result_stalls;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // output backpressure
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (result_stalls && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
      end
   end

   task automatic check_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         if (fail_count < REPORT_LIMIT)
            $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
         fail_count++;
      end
   endtask

   // result transfers are sampled mid-cycle, where the payload is stable
   always @(negedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_averages.size() == 0) begin
            if (fail_count < REPORT_LIMIT)
               $display("%0t: unexpected result expected none actual avg=%0d kept=%0d idx=%0d",
                        $time, rsp_ch.averaged_depth, rsp_ch.kept_samples,
                        rsp_ch.pixel_index);
            fail_count++;
         end else begin
            oldest_average = pending_averages.pop_front();
            check_field("averaged_depth", 32'(oldest_average.averaged_depth),
                        32'(rsp_ch.averaged_depth));
            check_field("kept_samples", 32'(oldest_average.kept_samples),
                        32'(rsp_ch.kept_samples));
            check_field("pixel_index", 32'(oldest_average.pixel_index),
                        32'(rsp_ch.pixel_index));
            check_field("frame_last", 32'(oldest_average.frame_last),
                        32'(rsp_ch.frame_last));
         end
      end
   end

   function automatic void accumulate_pixel(input logic [DEPTH_W-1:0] depth,
                                            input logic region);
      int unsigned      scans;
      int unsigned      cnt;
      longint unsigned  avg;
      bit               kept;
      bit               last_scan;
      pixel_result_type res;
      scans = (gate_scans == '0) ? 1 :
              ((int'(gate_scans) > MAX_SCANS) ? MAX_SCANS : int'(gate_scans));
      kept = depth != 0 && region && depth >= gate_min && depth <= gate_max;
      if (scan_pos == 0) begin
         depth_sum[pixel_pos] = kept ? SUM_W'(depth) : '0;
         hit_count[pixel_pos] = KEPT_W'(kept);
      end else if (kept) begin
         depth_sum[pixel_pos] = depth_sum[pixel_pos] + SUM_W'(depth);
         hit_count[pixel_pos] = hit_count[pixel_pos] + KEPT_W'(1);
      end
      last_scan = scan_pos + 1 >= scans;
      if (last_scan) begin
         cnt = 32'(hit_count[pixel_pos]);
         avg = (cnt == 0) ? 0 : (longint'(depth_sum[pixel_pos]) * 16 + cnt / 2) / cnt;
         res.averaged_depth = avg[AVG_W-1:0];
         res.kept_samples   = cnt[KEPT_W-1:0];
         res.pixel_index    = pixel_pos[INDEX_W-1:0];
         res.frame_last     = pixel_pos == PIXELS - 1;
         pending_averages.push_back(res);
      end
      pixel_pos++;
      if (pixel_pos == PIXELS) begin
         pixel_pos = 0;
         scan_pos = last_scan ? 0 : scan_pos + 1;
      end
   endfunction

   task automatic send_pixel(input logic [DEPTH_W-1:0] depth, input logic region);
      if (pixel_gaps && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.depth_sample <= depth;
      req_ch.in_region    <= region;
      do @(negedge clock); while (!req_ch.ready);
      @(posedge clock);
      accumulate_pixel(depth, region);
   endtask

   function automatic logic [DEPTH_W-1:0] pick_depth();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return gate_min;
         2:       return gate_max;
         3:       return gate_min - DEPTH_W'(1);
         4:       return gate_max + DEPTH_W'(1);
         5, 6:    return DEPTH_W'($urandom_range(0, 32767));
         default: begin
            if (gate_min <= gate_max) return DEPTH_W'($urandom_range(gate_min, gate_max));
            return DEPTH_W'($urandom);
         end
      endcase
   endfunction

   // stop the pixel stream and let the pipeline empty
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (pending_averages.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DAT_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(negedge clock); while (!csr_ch.ready);
      @(posedge clock);
      case (idx)
         CSR_MIN_DISTANCE: gate_min = value;
         CSR_MAX_DISTANCE: gate_max = value;
         CSR_SCAN_COUNT:   gate_scans = value[SCANS_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_gate(input int lo, input int hi, input int scans);
      drain_results();
      write_register(CSR_SPARE_INDEX, CSR_DAT_W'(lo ^ hi));
      write_register(CSR_MIN_DISTANCE, CSR_DAT_W'(lo));
      write_register(CSR_MAX_DISTANCE, CSR_DAT_W'(hi));
      write_register(CSR_SCAN_COUNT, CSR_DAT_W'(scans));
      csr_ch.valid <= 1'b0;
   endtask

   task automatic test_gate_edges();
      pixel_gaps    = 1'b0;
      result_stalls = 1'b1;
      // reset settings: scan 0 of five, nothing comes out
      send_pixel(15'd600, 1'b1);
      send_pixel(15'd450, 1'b1);
      send_pixel(15'd801, 1'b1);
      set_gate(100, 2000, 1);
      send_pixel(15'd0, 1'b1);
      send_pixel(15'd100, 1'b1);
      send_pixel(15'd99, 1'b1);
      send_pixel(15'd2000, 1'b1);
      send_pixel(15'd2001, 1'b1);
      send_pixel(15'd1500, 1'b0);
      send_pixel(15'd32767, 1'b1);
      // zero scan count acts as one
      set_gate(0, 32767, 0);
      send_pixel(15'd0, 1'b1);
      send_pixel(15'd1, 1'b1);
      send_pixel(15'd32767, 1'b1);
      send_pixel(15'd32767, 1'b0);
      // empty window
      set_gate(5000, 4000, 1);
      send_pixel(15'd4500, 1'b1);
      send_pixel(15'd5000, 1'b1);
      send_pixel(15'd4000, 1'b1);
      set_gate(32767, 32767, 16);
      send_pixel(15'd32767, 1'b1);
      send_pixel(15'd32766, 1'b1);
      set_gate(32767, 32767, 1);
      send_pixel(15'd32767, 1'b1);
      send_pixel(15'd32766, 1'b1);
   endtask

   task automatic test_random_gate();
      int lo;
      int hi;
      int scans;
      pixel_gaps    = 1'b1;
      result_stalls = 1'b1;
      for (int phase = 0; phase < 9; phase++) begin
         case ($urandom_range(0, 4))
            0: begin
               lo = 0;
               hi = 32767;
            end
            1: begin
               lo = $urandom_range(0, 32767);
               hi = $urandom_range(0, 32767);
            end
            2: begin
               lo = $urandom_range(1, 16000);
               hi = lo + $urandom_range(0, 16000);
            end
            default: begin
               lo = $urandom_range(0, 2000);
               hi = lo + $urandom_range(0, 3000);
            end
         endcase
         if (phase == 3) scans = 16;
         else if (phase == 5) scans = $urandom_range(2, 15);
         else if (phase == 7) scans = 31;
         else scans = ($urandom_range(0, 5) == 0) ? 0 : 1;
         set_gate(lo, hi, scans);
         repeat (160) send_pixel(pick_depth(), $urandom_range(0, 7) != 0);
      end
   endtask

   task automatic test_scan_lowering();
      // saturates to the maximum scan count; the first scan emits nothing
      set_gate(200, 28000, 31);
      pixel_gaps    = 1'b1;
      result_stalls = 1'b1;
      repeat (150) send_pixel(pick_depth(), $urandom_range(0, 7) != 0);
      // lowering the count makes the current scan the last one
      set_gate(1000, 20000, 1);
      pixel_gaps    = 1'b0;
      result_stalls = 1'b0;
      repeat (300) send_pixel(pick_depth(), $urandom_range(0, 7) != 0);
   endtask

   initial begin
      gate_min      = MIN_DIST_RESET;
      gate_max      = MAX_DIST_RESET;
      gate_scans    = SCANS_RESET;
      pixel_pos     = 0;
      scan_pos      = 0;
      fail_count    = 0;
      pixel_gaps    = 1'b0;
      result_stalls = 1'b0;
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.depth_sample <= '0;
      req_ch.in_region    <= 1'b0;
      csr_ch.valid        <= 1'b0;
      csr_ch.index        <= CSR_MIN_DISTANCE;
      csr_ch.data         <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_gate_edges();
      test_random_gate();
      test_scan_lowering();
      drain_results();

      if (fail_count == 0 && pending_averages.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
